FILE: hdl/handle_slot_table_macros.svh
// assertion macros for the handle slot table
`ifndef HANDLE_SLOT_TABLE_MACROS_SVH
`define HANDLE_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define HST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define HST_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HST_ASSERT(label, clk, rst, prop)
`define HST_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: hdl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// types and codes shared by the handle slot table
// ----------------------------------------------------------------------------
package hst_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_GET      = 3'd1,
    OP_GET_LAST = 3'd2,
    OP_FIND     = 3'd3,
    OP_DEL_IDX  = 3'd4,
    OP_DEL_HND  = 3'd5,
    OP_CLEAR    = 3'd6,
    OP_SORTED   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_INCONS   = 2'd3
  } status_t;

  localparam logic [2:0] REG_REUSE    = 3'd0;
  localparam logic [2:0] REG_SWAP     = 3'd1;
  localparam logic [2:0] REG_STAT     = 3'd2;
  localparam logic [2:0] REG_COMPACT  = 3'd3;
  localparam logic [2:0] REG_ORDER    = 3'd4;
  localparam logic [2:0] REG_CONSERVE = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  slot_index;
    logic [31:0] handle_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_index;
    logic [31:0] handle_out;
    logic [8:0]  entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_HOLE_RD,
    S_HOLE_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_LAST_RD,
    S_LAST_CHK,
    S_DEL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SWAP_RD,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_DONE
  } state_t;

endpackage

FILE: hdl/handle_slot_table.sv
// ----------------------------------------------------------------------------
// handle_slot_table
// fixed-capacity table of handles with add, lookup, clear and policy-driven delete
// ----------------------------------------------------------------------------
// channel  direction  payload     handshake
// in       input      in_item_t   in_valid / in_stall
// out      output     out_item_t  out_valid / out_stall
// cfg      input      cfg_data    cfg_we, cfg_index
//
// one item at a time; a sequencer walks the single slot-store read port,
// reading and then checking each slot visited (hole search, find, trim) or
// reading then writing (compaction shift); the worst case is an ordered
// compacting delete of slot 0 followed by a conserve trim down to it.
// rst clears control state; slot contents stay undefined until written.
// the result waits in an output register while out_stall is high; the next
// item is taken once that register is free.
module handle_slot_table #(
  parameter int CAPACITY    = 256,
  parameter int HANDLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hst_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hst_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic                cfg_data
);
  import hst_pkg::*;
`include "handle_slot_table_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // configuration bits
  logic reuse_holes, swap_on_delete, stationary_slots;
  logic compact_on_delete, keep_order, conserve_extent;

  always_ff @(posedge clk) begin
    if (rst) begin
      reuse_holes <= 1'b0; swap_on_delete <= 1'b0; stationary_slots <= 1'b0;
      compact_on_delete <= 1'b0; keep_order <= 1'b0; conserve_extent <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REUSE:    reuse_holes       <= cfg_data;
        REG_SWAP:     swap_on_delete    <= cfg_data;
        REG_STAT:     stationary_slots  <= cfg_data;
        REG_COMPACT:  compact_on_delete <= cfg_data;
        REG_ORDER:    keep_order        <= cfg_data;
        REG_CONSERVE: conserve_extent   <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot store, one read and one write port
  logic [HANDLE_BITS-1:0] mem [CAPACITY];
  logic                   mem_we;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [HANDLE_BITS-1:0] mem_wd, mem_rd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  // table state and working registers
  state_t state, state_next;
  logic [CW-1:0] extent, extent_next, occupancy, occupancy_next;
  logic [CW-1:0] free_hint, free_hint_next;
  logic          sorted_mark, sorted_mark_next;
  logic [2:0]    op, op_next;
  logic [CW-1:0] cur, cur_next;      // walking pointer
  logic [CW-1:0] del_i, del_i_next;  // slot being deleted
  logic [HANDLE_BITS-1:0] hnd, hnd_next;
  logic          hint_set, hint_set_next;
  out_item_t     res, res_next;
  logic          res_valid, res_valid_next;

  assign in_stall  = (state != S_IDLE) || res_valid;
  assign out_valid = res_valid;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; extent <= '0; occupancy <= '0; free_hint <= '0;
      sorted_mark <= 1'b0; res_valid <= 1'b0;
    end else begin
      state <= state_next; extent <= extent_next; occupancy <= occupancy_next;
      free_hint <= free_hint_next; sorted_mark <= sorted_mark_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next; cur <= cur_next; del_i <= del_i_next; hnd <= hnd_next;
    hint_set <= hint_set_next; res <= res_next;
  end

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // sequencer
  always_comb begin
    state_next = state; extent_next = extent; occupancy_next = occupancy;
    free_hint_next = free_hint; sorted_mark_next = sorted_mark;
    op_next = op; cur_next = cur; del_i_next = del_i; hnd_next = hnd;
    hint_set_next = hint_set; res_next = res;
    res_valid_next = res_valid && out_stall;
    mem_we = 1'b0; mem_wa = cur[AW-1:0]; mem_wd = '0; mem_ra = cur[AW-1:0];

    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          op_next  = in_data.operation;
          hnd_next = HANDLE_BITS'(in_data.handle_in);
          // an index past the store can never be below extent
          cur_next = (32'(in_data.slot_index) >= CAPACITY) ? CAP :
                     CW'(in_data.slot_index);
          res_next = '0;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (op_t'(op))
          OP_ADD: begin
            sorted_mark_next = 1'b0;
            if ((reuse_holes || conserve_extent) && !keep_order &&
                occupancy < extent) begin
              cur_next = free_hint;
              state_next = S_HOLE_RD;
            end else begin
              state_next = S_HOLE_CHK;
              cur_next = extent;  // marks no hole
            end
          end
          OP_GET, OP_DEL_IDX: begin
            if (cur >= extent) begin
              res_next.status = ST_NOTFOUND;
              state_next = S_DONE;
            end else begin
              state_next = S_FIND_CHK;  // read already addressed by cur
              hnd_next = '0;
            end
          end
          OP_GET_LAST: begin
            if (occupancy == '0) begin
              res_next.status = ST_NOTFOUND;
              state_next = S_DONE;
            end else begin
              cur_next = extent;
              state_next = S_LAST_RD;
            end
          end
          OP_FIND, OP_DEL_HND: begin
            cur_next = '0;
            if (hnd == '0) begin
              res_next.status = ST_NOTFOUND;
              state_next = S_DONE;
            end else begin
              state_next = S_FIND_RD;
            end
          end
          OP_CLEAR: begin
            extent_next = '0; free_hint_next = '0; occupancy_next = '0;
            state_next = S_DONE;
          end
          default: begin
            sorted_mark_next = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end

      // hole search from the hint: read then check
      S_HOLE_RD: begin
        if (cur < extent) state_next = S_HOLE_CHK;
        else begin
          free_hint_next = cur;
          cur_next = extent;
          state_next = S_HOLE_CHK;
        end
      end

      S_HOLE_CHK: begin
        if (cur < extent && mem_rd != '0) begin
          cur_next = cur + 1'b1;
          state_next = S_HOLE_RD;
        end else begin
          if (cur < extent) begin
            mem_we = 1'b1; mem_wa = cur[AW-1:0]; mem_wd = hnd;
            free_hint_next = cur + 1'b1;
          end else if (extent >= CAP) begin
            res_next.status = ST_FULL;
          end else begin
            mem_we = 1'b1; mem_wa = extent[AW-1:0]; mem_wd = hnd;
            extent_next = extent + 1'b1;
          end
          if (cur < extent || extent < CAP) begin
            if (occupancy < CAP) occupancy_next = occupancy + 1'b1;
            res_next.result_index = cur < extent ? 8'(cur) : 8'(extent);
            res_next.handle_out = 32'(hnd);
          end
          state_next = S_DONE;
        end
      end

      // find by handle, or index lookup when hnd is zero
      S_FIND_RD: begin
        if (cur < extent) state_next = S_FIND_CHK;
        else begin
          res_next.status = ST_NOTFOUND;
          state_next = S_DONE;
        end
      end

      S_FIND_CHK: begin
        if (hnd != '0 && mem_rd != hnd) begin
          cur_next = cur + 1'b1;
          state_next = S_FIND_RD;
        end else begin
          res_next.result_index = 8'(cur);
          res_next.handle_out = 32'(mem_rd);
          if (op == OP_DEL_IDX || op == OP_DEL_HND) begin
            del_i_next = cur;
            state_next = S_DEL;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      // get last occupied: walk down from extent
      S_LAST_RD: begin
        if (cur == '0) begin
          res_next.status = ST_INCONS;
          state_next = S_DONE;
        end else begin
          mem_ra = AW'(cur - 1'b1);
          state_next = S_LAST_CHK;
        end
      end

      S_LAST_CHK: begin
        if (mem_rd == '0) begin
          cur_next = cur - 1'b1;
          state_next = S_LAST_RD;
        end else begin
          res_next.result_index = 8'(cur - 1'b1);
          res_next.handle_out = 32'(mem_rd);
          state_next = S_DONE;
        end
      end

      // delete policy decision
      S_DEL: begin
        if (occupancy > '0) occupancy_next = occupancy - 1'b1;
        hint_set_next = 1'b0;
        if (!stationary_slots && (sorted_mark || keep_order) && compact_on_delete) begin
          extent_next = extent - 1'b1;
          cur_next = del_i;
          state_next = S_SHIFT_RD;
        end else if (!stationary_slots && !(sorted_mark || keep_order) &&
                     (swap_on_delete || compact_on_delete) &&
                     del_i < extent - 1'b1) begin
          mem_ra = AW'(extent - 1'b1);
          sorted_mark_next = 1'b0;
          state_next = S_SWAP_RD;
        end else begin
          mem_we = 1'b1; mem_wa = del_i[AW-1:0]; mem_wd = '0;
          if (del_i == extent - 1'b1) extent_next = extent - 1'b1;
          hint_set_next = 1'b1;
          cur_next = extent_next;
          state_next = S_TRIM_RD;
        end
      end

      // compaction shift: slot j takes slot j + 1
      S_SHIFT_RD: begin
        if (cur < extent) begin
          mem_ra = AW'(cur + 1'b1);
          state_next = S_SHIFT_WR;
        end else begin
          mem_we = 1'b1; mem_wa = extent[AW-1:0]; mem_wd = '0;
          cur_next = extent;
          state_next = S_TRIM_RD;
        end
      end

      S_SHIFT_WR: begin
        mem_we = 1'b1; mem_wa = cur[AW-1:0]; mem_wd = mem_rd;
        cur_next = cur + 1'b1;
        state_next = S_SHIFT_RD;
      end

      // swap last entry into the freed slot; the old last slot now lies
      // at or above extent and is rewritten before it is next read
      S_SWAP_RD: begin
        mem_we = 1'b1; mem_wa = del_i[AW-1:0]; mem_wd = mem_rd;
        extent_next = extent - 1'b1;
        cur_next = extent - 1'b1;
        state_next = S_TRIM_RD;
      end

      // trim trailing holes down to the deleted slot when conserve_extent is set
      S_TRIM_RD: begin
        if (conserve_extent && extent > del_i) begin
          mem_ra = AW'(extent - 1'b1);
          state_next = S_TRIM_CHK;
        end else begin
          if (hint_set && del_i < free_hint) free_hint_next = del_i;
          state_next = S_DONE;
        end
      end

      S_TRIM_CHK: begin
        if (mem_rd == '0) begin
          extent_next = extent - 1'b1;
          state_next = S_TRIM_RD;
        end else begin
          if (hint_set && del_i < free_hint) free_hint_next = del_i;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        res_next.entry_count = 9'(occupancy);
        res_valid_next = 1'b1;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  `HST_ASSERT(a_one_out, clk, rst, (out_valid && out_stall) |=> out_valid)
  `HST_ASSERT(a_occ_cap, clk, rst, occupancy <= CAP)
  `HST_ASSERT(a_ext_cap, clk, rst, extent <= CAP)
  `HST_ASSERT(a_stall_busy, clk, rst, (state != S_IDLE) |-> in_stall)
  `HST_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> $stable(out_data))

endmodule
